// ===== rtl/b2r_pkg.sv =====
package b2r_pkg;

    // bit counts of the two symbol kinds, and bytes per padding group
    localparam int SYM_BITS    = 5;
    localparam int BYTE_BITS   = 8;
    localparam int GROUP_BYTES = 5;

    // accumulator and counter widths
    localparam int ACC_W   = 12;
    localparam int HELD_W  = 4;
    localparam int PHASE_W = 3;

    // one input beat
    typedef struct packed {
        logic [BYTE_BITS-1:0] value;
        logic                 last;
    } t_item;

    // one result beat
    typedef struct packed {
        logic [BYTE_BITS-1:0] value;
        logic                 has_data;
        logic                 last;
    } t_result;

endpackage

// ===== rtl/b2r_in_reg.sv =====
module b2r_in_reg import b2r_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_stall,
    input  logic  i_take,
    output logic  o_avail,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // hold the beat until the core takes it
    assign o_stall = r_valid && !i_take;
    assign o_avail = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/b2r_core.sv =====
module b2r_core import b2r_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_wr_en,
    input  logic    i_cfg_wr_data,
    input  logic    i_avail,
    input  t_item   i_item,
    input  logic    i_out_ready,
    output logic    o_take,
    output logic    o_emit,
    output t_result o_result
);

    logic               r_mode;
    logic [ACC_W-1:0]   r_acc;
    logic [HELD_W-1:0]  r_held;
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] r_pad;
    logic               r_fin;

    logic [ACC_W-1:0]   n_acc;
    logic [HELD_W-1:0]  n_held;
    logic [PHASE_W-1:0] n_phase;
    logic [PHASE_W-1:0] n_pad;
    logic               n_fin;

    logic               pending;
    logic               step;
    logic [ACC_W-1:0]   v_acc;
    logic [HELD_W-1:0]  v_held;
    logic [PHASE_W-1:0] v_pad;
    logic               v_fin;
    logic [ACC_W-1:0]   shifted;
    logic [ACC_W-1:0]   keep_mask;
    logic               res_last;

    // encode still owes symbols from an earlier byte or from padding
    assign pending = r_mode && ((r_held >= HELD_W'(SYM_BITS)) || (r_pad != '0));
    assign o_take  = i_avail && i_out_ready && !pending;
    assign step    = i_out_ready && (pending || i_avail);

    // one regroup step: encode loads optionally, pads optionally and extracts one symbol; decode appends one symbol
    always_comb begin
        v_acc     = r_acc;
        v_held    = r_held;
        v_pad     = r_pad;
        v_fin     = r_fin;
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_held    = r_held;
        n_pad     = r_pad;
        n_fin     = r_fin;
        shifted   = '0;
        keep_mask = '0;
        res_last  = 1'b0;
        o_emit    = 1'b0;
        o_result  = '0;

        if (r_mode) begin
            // load a new byte; held bits are at most four here
            if (!pending) begin
                v_acc   = {r_acc[ACC_W-BYTE_BITS-1:0], i_item.value};
                v_held  = r_held + HELD_W'(BYTE_BITS);
                v_fin   = i_item.last;
                n_phase = (r_phase == PHASE_W'(GROUP_BYTES - 1)) ? '0 : r_phase + 1'b1;
                if (i_item.last && (n_phase != '0)) begin
                    v_pad = PHASE_W'(GROUP_BYTES) - n_phase;
                end else begin
                    v_pad = '0;
                end
            end
            // shift in a padding zero byte when short of a symbol
            if ((v_held < HELD_W'(SYM_BITS)) && (v_pad != '0)) begin
                v_acc  = {v_acc[ACC_W-BYTE_BITS-1:0], {BYTE_BITS{1'b0}}};
                v_held = v_held + HELD_W'(BYTE_BITS);
                v_pad  = v_pad - 1'b1;
            end
            n_held    = v_held - HELD_W'(SYM_BITS);
            shifted   = v_acc >> n_held;
            keep_mask = ~({ACC_W{1'b1}} << n_held);
            n_acc     = v_acc & keep_mask;
            n_pad     = v_pad;
            n_fin     = v_fin;
            res_last  = v_fin && (n_held < HELD_W'(SYM_BITS)) && (v_pad == '0);
            o_emit    = step;
            o_result.value    = {{(BYTE_BITS-SYM_BITS){1'b0}}, shifted[SYM_BITS-1:0]};
            o_result.has_data = 1'b1;
            o_result.last     = res_last;
        end else begin
            // decode: append five bits, a byte comes out once eight or more are held
            v_acc  = {r_acc[ACC_W-SYM_BITS-1:0], i_item.value[SYM_BITS-1:0]};
            v_held = r_held + HELD_W'(SYM_BITS);
            if (v_held >= HELD_W'(BYTE_BITS)) begin
                n_held            = v_held - HELD_W'(BYTE_BITS);
                shifted           = v_acc >> n_held;
                o_emit            = step;
                o_result.value    = shifted[BYTE_BITS-1:0];
                o_result.has_data = 1'b1;
                o_result.last     = i_item.last;
            end else begin
                n_held = v_held;
                // empty end marker
                if (i_item.last) begin
                    o_emit        = step;
                    o_result.last = 1'b1;
                end
            end
            keep_mask = ~({ACC_W{1'b1}} << n_held);
            n_acc     = v_acc & keep_mask;
            res_last  = i_item.last;
            n_pad     = '0;
            n_fin     = 1'b0;
        end

        // end of buffer returns the regroup state to zero
        if (res_last) begin
            n_acc   = '0;
            n_held  = '0;
            n_phase = '0;
            n_pad   = '0;
            n_fin   = 1'b0;
        end
    end

    // mode and regroup state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_acc   <= '0;
            r_held  <= '0;
            r_phase <= '0;
            r_pad   <= '0;
            r_fin   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode  <= i_cfg_wr_data;
            r_acc   <= '0;
            r_held  <= '0;
            r_phase <= '0;
            r_pad   <= '0;
            r_fin   <= 1'b0;
        end else if (step) begin
            r_acc   <= n_acc;
            r_held  <= n_held;
            r_phase <= n_phase;
            r_pad   <= n_pad;
            r_fin   <= n_fin;
        end
    end

    // held count never exceeds the accumulator width
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_W'(ACC_W))
        else $error("bit count out of range");

    // final result of a buffer leaves the state cleared
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit && o_result.last |=> (r_held == '0) && (r_pad == '0) && !r_fin)
        else $error("state not cleared after end of buffer");

    // padding is only owed at the end of a buffer
    a_pad_needs_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad != '0) |-> r_fin && r_mode)
        else $error("padding outside end of buffer");

    // no new beat is taken while encode symbols are still owed
    a_no_take_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pending |-> !o_take)
        else $error("beat taken while symbols pending");

endmodule

// ===== rtl/b2r_out_reg.sv =====
module b2r_out_reg import b2r_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_emit,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // free when empty or when the held beat leaves this cycle
    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_emit) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/byte_to_5bit_regrouper.sv =====
// Regroups a bit stream between bytes and 5-bit symbols, MSB first.
// Input channel: i_in_valid / o_in_stall with i_in_value and i_in_last.
// Output channel: o_out_valid / i_out_stall with o_out_value,
// o_out_has_data and o_out_last. A beat moves when valid is high and
// stall is low. i_cfg_wr_en writes i_cfg_wr_data as the mode
// (1 encode, 0 decode) and clears the regroup state; write only when idle.
// Encode: each byte gives one or two symbols; the last byte of a buffer is
// zero padded to a 5-byte group and gives up to eight symbols, the final
// one carrying o_out_last. Decode: each input gives at most one byte; a
// last input that completes no byte gives one beat with o_out_has_data=0.
// A taken beat passes through the input register, then the result
// register, before it shows on the output. The result register moves
// one beat per cycle while i_out_stall is low. Decode takes an input
// item whenever the result register is free; encode gives one symbol
// per beat and takes no new byte while symbols or padding are owed.
// A stall on the output holds the result register; the input register
// then fills and o_in_stall rises. Reset sets encode mode, empties both
// registers and clears the accumulator, bit count and byte phase.
module byte_to_5bit_regrouper import b2r_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_BITS-1:0] i_in_value,
    input  logic                 i_in_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_BITS-1:0] o_out_value,
    output logic                 o_out_has_data,
    output logic                 o_out_last
);

    t_item   in_item;
    t_item   core_item;
    t_result core_result;
    t_result out_result;
    logic    core_avail;
    logic    core_take;
    logic    core_emit;
    logic    out_ready;

    assign in_item.value = i_in_value;
    assign in_item.last  = i_in_last;

    b2r_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .o_stall (o_in_stall),
        .i_take  (core_take),
        .o_avail (core_avail),
        .o_item  (core_item)
    );

    b2r_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_avail       (core_avail),
        .i_item        (core_item),
        .i_out_ready   (out_ready),
        .o_take        (core_take),
        .o_emit        (core_emit),
        .o_result      (core_result)
    );

    b2r_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (core_emit),
        .i_result (core_result),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_out_value    = out_result.value;
    assign o_out_has_data = out_result.has_data;
    assign o_out_last     = out_result.last;

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import b2r_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int MAX_REPORTS      = 10;

    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_wr_en    = 1'b0;
    logic                 i_cfg_wr_data  = 1'b1;
    logic                 i_in_valid     = 1'b0;
    logic [BYTE_BITS-1:0] i_in_value     = '0;
    logic                 i_in_last      = 1'b0;
    logic                 i_out_stall    = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [BYTE_BITS-1:0] o_out_value;
    logic                 o_out_has_data;
    logic                 o_out_last;

    // stimulus and expected beats
    t_item   src_q[$];
    t_result regrouped_q[$];

    // predictor copy of the regroup state
    logic               enc_mode;
    logic [ACC_W-1:0]   acc_bits;
    logic [HELD_W-1:0]  bits_held;
    logic [PHASE_W-1:0] byte_phase;

    // knobs shared by the stimulus processes
    int  src_idle_pct  = 0;
    int  sink_idle_pct = 0;
    bit  calm          = 1'b0;
    int  hold_reqs     = 0;
    bit  in_taken      = 1'b0;
    int  mismatches    = 0;

    byte_to_5bit_regrouper dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_value     (i_in_value),
        .i_in_last      (i_in_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_value    (o_out_value),
        .o_out_has_data (o_out_has_data),
        .o_out_last     (o_out_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic void clear_regroup();
        acc_bits   = '0;
        bits_held  = '0;
        byte_phase = '0;
    endfunction

    function automatic void push_result(logic [BYTE_BITS-1:0] v, logic has, logic lst);
        t_result r;
        r.value    = v;
        r.has_data = has;
        r.last     = lst;
        regrouped_q.push_back(r);
    endfunction

    // append one byte, emit every full 5-bit group
    function automatic void enc_take_byte(logic [BYTE_BITS-1:0] b);
        acc_bits  = {acc_bits[3:0], b};
        bits_held = bits_held + 4'd8;
        while (bits_held >= SYM_BITS) begin
            bits_held = bits_held - 4'd5;
            push_result(BYTE_BITS'((acc_bits >> bits_held) & 12'h01f), 1'b1, 1'b0);
        end
        acc_bits   = acc_bits & ((12'd1 << bits_held) - 12'd1);
        byte_phase = (byte_phase == 3'(GROUP_BYTES - 1)) ? 3'd0 : byte_phase + 3'd1;
    endfunction

    function automatic void regroup_beat(logic [BYTE_BITS-1:0] v, logic lst);
        bit got_byte;
        got_byte = 1'b0;
        if (enc_mode) begin
            enc_take_byte(v);
            if (lst) begin
                // zero pad up to a whole 5-byte group, then flush
                while (byte_phase != 0)
                    enc_take_byte('0);
                regrouped_q[$].last = 1'b1;
                clear_regroup();
            end
        end else begin
            acc_bits  = {acc_bits[6:0], v[4:0]};
            bits_held = bits_held + 4'd5;
            if (bits_held >= BYTE_BITS) begin
                bits_held = bits_held - 4'd8;
                push_result(BYTE_BITS'((acc_bits >> bits_held) & 12'h0ff), 1'b1, lst);
                got_byte = 1'b1;
            end
            acc_bits = acc_bits & ((12'd1 << bits_held) - 12'd1);
            if (lst) begin
                // empty end marker when the last symbol completes no byte
                if (!got_byte)
                    push_result('0, 1'b0, 1'b1);
                clear_regroup();
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // monitor: config tracking, result check, input prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            enc_mode = 1'b1;
            clear_regroup();
        end else begin
            if (i_cfg_wr_en) begin
                enc_mode = i_cfg_wr_data;
                clear_regroup();
            end
            if (o_out_valid && !i_out_stall) begin
                if (regrouped_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected beat value=%h has_data=%b last=%b",
                                 $realtime, o_out_value, o_out_has_data, o_out_last);
                end else begin
                    want = regrouped_q.pop_front();
                    if (o_out_value !== want.value || o_out_has_data !== want.has_data ||
                        o_out_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: exp value=%h has_data=%b last=%b, got %h %b %b",
                                     $realtime, want.value, want.has_data, want.last,
                                     o_out_value, o_out_has_data, o_out_last);
                    end
                end
            end
            if (in_taken)
                regroup_beat(i_in_value, i_in_last);
        end
    end

    // ---------------------------------------------------------------
    // driver: input beats with random gaps
    // ---------------------------------------------------------------
    int src_gap = 0;

    always @(negedge i_clk) begin : driver
        t_item b;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (calm)
                src_gap = 0;
            if (src_gap > 0) begin
                src_gap--;
                i_in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
                src_gap = $urandom_range(0, 12);
                i_in_valid <= 1'b0;
            end else if (src_q.size() > 0) begin
                b = src_q.pop_front();
                i_in_value <= b.value;
                i_in_last  <= b.last;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // sink stall: random bursts plus the requested long hold-off
    // ---------------------------------------------------------------
    int sink_gap  = 0;
    int hold_left = 0;
    int hold_done = 0;

    always @(negedge i_clk) begin : sink_stall
        if (hold_reqs != hold_done) begin
            hold_done++;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (calm) begin
            sink_gap = 0;
            i_out_stall <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            sink_gap = $urandom_range(0, 12);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // stimulus sequence
    // ---------------------------------------------------------------
    task automatic add_beat(logic [BYTE_BITS-1:0] v, logic lst);
        t_item b;
        b.value = v;
        b.last  = lst;
        src_q.push_back(b);
    endtask

    // mostly whole buffers, some loose beats with a random last flag
    task automatic add_buffers(int n);
        int cnt;
        int len;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(0, 99) < 15) begin
                add_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                cnt++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20)
                                                  : $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    add_beat(8'($urandom_range(0, 255)), k == len - 1);
                cnt += len;
            end
        end
    endtask

    // block until every beat is sent and every result has come back
    task automatic wait_idle();
        do @(posedge i_clk);
        while (src_q.size() != 0 || i_in_valid || regrouped_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(logic m);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed encode: padding from one byte, exact group, wrap into padding
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        set_mode(1'b1);
        add_beat(8'h00, 1'b1);
        add_beat(8'h80, 1'b0);
        add_beat(8'h01, 1'b0);
        add_beat(8'h7f, 1'b0);
        add_beat(8'hfe, 1'b0);
        add_beat(8'h55, 1'b1);
        for (int k = 0; k < 5; k++)
            add_beat(8'hff, 1'b0);
        add_beat(8'h0f, 1'b1);
        wait_idle();

        // directed decode: empty end, ignored upper bits, full 40-bit group,
        // byte followed by an empty end
        set_mode(1'b0);
        add_beat(8'h1f, 1'b1);
        add_beat(8'he0, 1'b0);
        add_beat(8'hff, 1'b1);
        add_beat(8'h1f, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'h15, 1'b0);
        add_beat(8'h0a, 1'b0);
        add_beat(8'he1, 1'b0);
        add_beat(8'h10, 1'b0);
        add_beat(8'h03, 1'b0);
        add_beat(8'h1c, 1'b1);
        add_beat(8'h01, 1'b0);
        add_beat(8'h02, 1'b0);
        add_beat(8'h03, 1'b1);
        // partial buffer, then a mode write must drop the held bits
        add_beat(8'h1b, 1'b0);
        wait_idle();
        set_mode(1'b0);
        add_beat(8'h07, 1'b0);
        add_beat(8'h19, 1'b1);
        wait_idle();

        // random encode
        src_idle_pct  = 30;
        sink_idle_pct = 30;
        set_mode(1'b1);
        add_buffers(70);
        wait_idle();

        // decode under a long sink hold-off so the input side backs up
        set_mode(1'b0);
        hold_reqs++;
        add_buffers(50);
        wait_idle();

        // encode with a sender pause until all results are back
        set_mode(1'b1);
        add_buffers(35);
        wait_idle();
        add_buffers(35);
        wait_idle();

        // encode with no idling, decode with heavy idling
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        add_buffers(50);
        wait_idle();
        src_idle_pct  = 50;
        sink_idle_pct = 50;
        set_mode(1'b0);
        add_buffers(50);
        wait_idle();

        // last part: no idling on either side
        calm = 1'b1;
        set_mode(1'b1);
        add_buffers(50);
        wait_idle();
        set_mode(1'b0);
        add_buffers(30);
        wait_idle();

        repeat (20) @(posedge i_clk);
        mismatches += regrouped_q.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
